@@ hdl/gmpt_pkg.sv @@
package gmpt_pkg;

    // Axis count and per-axis index width
    localparam int AXES   = 3;
    localparam int AXIS_W = 2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_OFFSET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_OFFSET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WORK_OFFSET_Z = 2'd2;

    // Word letter codes
    localparam logic [2:0] LETTER_X = 3'd0;
    localparam logic [2:0] LETTER_Y = 3'd1;
    localparam logic [2:0] LETTER_Z = 3'd2;
    localparam logic [2:0] LETTER_G = 3'd3;

    // G numbers with the decimal point dropped
    localparam logic [13:0] G_NO_OFFSET = 14'd53;
    localparam logic [13:0] G_PLANE_XY  = 14'd17;
    localparam logic [13:0] G_PLANE_YZ  = 14'd19;
    localparam logic [13:0] G_INCH      = 14'd20;
    localparam logic [13:0] G_MM        = 14'd21;
    localparam logic [13:0] G_ABS       = 14'd90;
    localparam logic [13:0] G_REL       = 14'd91;

    localparam logic [0:0] MODE_WORD = 1'b0;
    localparam logic [0:0] MODE_EOL  = 1'b1;

    // Input beat
    typedef struct packed {
        logic               mode;
        logic [2:0]         word_letter;
        logic signed [31:0] word_value;
        logic [13:0]        g_number;
        logic               skip_line;
        logic               bad_word;
    } in_beat_t;

    // Result beat
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic               relative_mode;
        logic               inch_units;
        logic [1:0]         plane;
    } out_beat_t;

    // Classified command passed from front to back
    typedef enum logic [3:0] {
        OP_NOP,
        OP_ABORT,
        OP_AXIS,
        OP_NO_OFFSET,
        OP_PLANE,
        OP_INCH,
        OP_MM,
        OP_ABS,
        OP_REL,
        OP_EOL,
        OP_EOL_SKIP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [AXIS_W-1:0]  axis;
        logic signed [31:0] value;
        logic [1:0]         plane;
    } cmd_t;

    // Signed 32-bit add, clamped to the 32-bit range
    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = {a[31], a} + {b[31], b};
        if (s[32] != s[31])
        begin
            sat_add = s[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        else
        begin
            sat_add = s[31:0];
        end
    endfunction

endpackage

@@ hdl/gmpt_front.sv @@
module gmpt_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  gmpt_pkg::in_beat_t in_data,
    output logic              cmd_valid,
    input  logic              cmd_full,
    output gmpt_pkg::cmd_t    cmd
);
    import gmpt_pkg::*;

    logic  valid_reg;
    cmd_t  cmd_reg;
    cmd_t  cmd_next;
    logic  load;

    // Classify one beat into a command
    always_comb
    begin
        cmd_next.op    = OP_NOP;
        cmd_next.axis  = in_data.word_letter[AXIS_W-1:0];
        cmd_next.value = in_data.word_value;
        cmd_next.plane = 2'(in_data.g_number - G_PLANE_XY);
        if (in_data.mode == MODE_EOL)
        begin
            cmd_next.op = in_data.skip_line ? OP_EOL_SKIP : OP_EOL;
        end
        else if (in_data.skip_line)
        begin
            cmd_next.op = OP_NOP;
        end
        else if (in_data.bad_word)
        begin
            cmd_next.op = OP_ABORT;
        end
        else if (in_data.word_letter == LETTER_X || in_data.word_letter == LETTER_Y ||
                 in_data.word_letter == LETTER_Z)
        begin
            cmd_next.op = OP_AXIS;
        end
        else if (in_data.word_letter == LETTER_G)
        begin
            if (in_data.g_number == G_NO_OFFSET)
                cmd_next.op = OP_NO_OFFSET;
            else if (in_data.g_number >= G_PLANE_XY && in_data.g_number <= G_PLANE_YZ)
                cmd_next.op = OP_PLANE;
            else if (in_data.g_number == G_INCH)
                cmd_next.op = OP_INCH;
            else if (in_data.g_number == G_MM)
                cmd_next.op = OP_MM;
            else if (in_data.g_number == G_ABS)
                cmd_next.op = OP_ABS;
            else if (in_data.g_number == G_REL)
                cmd_next.op = OP_REL;
        end
    end

    // Stage register: refills whenever it is empty or hands its beat on
    assign in_stall  = valid_reg && cmd_full;
    assign load      = !in_stall;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (load)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && in_valid)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

@@ hdl/gmpt_queue.sv @@
module gmpt_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gmpt_pkg::cmd_t  push_cmd,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output gmpt_pkg::cmd_t  head_cmd
);
    import gmpt_pkg::*;

    localparam int DEPTH = 2;

    cmd_t       mem [DEPTH];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       do_push;

    assign full       = (count_reg == 2'(DEPTH));
    assign head_valid = (count_reg != 2'd0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_push    = push && !full;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !do_push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

`ifndef SYNTHESIS
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> count_reg != 2'd0)
        else $error("queue popped while empty");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'(DEPTH))
        else $error("queue level beyond depth");
`endif

endmodule

@@ hdl/gmpt_back.sv @@
module gmpt_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [gmpt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [31:0]                       cfg_wdata,
    input  logic                              cmd_valid,
    input  gmpt_pkg::cmd_t                    cmd,
    output logic                              cmd_pop,
    output logic                              out_valid,
    input  logic                              out_stall,
    output gmpt_pkg::out_beat_t               out_data
);
    import gmpt_pkg::*;

    logic signed [31:0] offset_reg [AXES];
    logic signed [31:0] pos_reg    [AXES];
    logic signed [31:0] pos_next   [AXES];
    logic signed [31:0] tgt_reg    [AXES];
    logic signed [31:0] tgt_next   [AXES];
    logic signed [31:0] commit_sum [AXES];
    logic [AXES-1:0]    pend_reg, pend_next;
    logic               off_en_reg, off_en_next;
    logic               aborted_reg, aborted_next;
    logic               rel_reg, rel_next;
    logic               inch_reg, inch_next;
    logic [1:0]         plane_reg, plane_next;
    logic               out_valid_reg;
    out_beat_t          out_reg;
    logic signed [31:0] axis_pos;
    logic signed [31:0] rel_target;
    logic               execute;
    logic               add_off;

    // Take a command when the result register is free or being drained
    assign execute   = cmd_valid && (!out_valid_reg || !out_stall);
    assign cmd_pop   = execute;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign add_off   = off_en_reg && !rel_reg;

    // Work offset registers; writes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
                offset_reg[i] <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WORK_OFFSET_X: offset_reg[0] <= cfg_wdata;
                CFG_WORK_OFFSET_Y: offset_reg[1] <= cfg_wdata;
                CFG_WORK_OFFSET_Z: offset_reg[2] <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Commit adders, one per axis
    always_comb
    begin
        for (int i = 0; i < AXES; i++)
            commit_sum[i] = sat_add(tgt_reg[i], offset_reg[i]);
    end

    // Relative target for the addressed axis
    always_comb
    begin
        axis_pos = pos_reg[0];
        for (int i = 0; i < AXES; i++)
            if (cmd.axis == AXIS_W'(i))
                axis_pos = pos_reg[i];
        rel_target = sat_add(axis_pos, cmd.value);
    end

    // Next state
    always_comb
    begin
        pos_next     = pos_reg;
        tgt_next     = tgt_reg;
        pend_next    = pend_reg;
        off_en_next  = off_en_reg;
        aborted_next = aborted_reg;
        rel_next     = rel_reg;
        inch_next    = inch_reg;
        plane_next   = plane_reg;
        if (execute)
        begin
            if (cmd.op == OP_EOL || cmd.op == OP_EOL_SKIP)
            begin
                if (cmd.op == OP_EOL && !aborted_reg)
                begin
                    for (int i = 0; i < AXES; i++)
                        if (pend_reg[i])
                            pos_next[i] = add_off ? commit_sum[i] : tgt_reg[i];
                end
                pend_next    = '0;
                off_en_next  = 1'b1;
                aborted_next = 1'b0;
            end
            else if (!aborted_reg)
            begin
                unique case (cmd.op)
                    OP_ABORT:     aborted_next = 1'b1;
                    OP_AXIS:
                    begin
                        for (int i = 0; i < AXES; i++)
                        begin
                            if (cmd.axis == AXIS_W'(i))
                            begin
                                tgt_next[i]  = rel_reg ? rel_target : cmd.value;
                                pend_next[i] = 1'b1;
                            end
                        end
                    end
                    OP_NO_OFFSET: off_en_next = 1'b0;
                    OP_PLANE:     plane_next  = cmd.plane;
                    OP_INCH:      inch_next   = 1'b1;
                    OP_MM:        inch_next   = 1'b0;
                    OP_ABS:       rel_next    = 1'b0;
                    OP_REL:       rel_next    = 1'b1;
                    default: ;
                endcase
            end
        end
    end

    // Tracker state and result flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < AXES; i++)
                pos_reg[i] <= '0;
            pend_reg      <= '0;
            off_en_reg    <= 1'b1;
            aborted_reg   <= 1'b0;
            rel_reg       <= 1'b0;
            inch_reg      <= 1'b0;
            plane_reg     <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            pend_reg    <= pend_next;
            off_en_reg  <= off_en_next;
            aborted_reg <= aborted_next;
            rel_reg     <= rel_next;
            inch_reg    <= inch_next;
            plane_reg   <= plane_next;
            if (execute)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Pending targets only count while their bit is set
    always_ff @(posedge clk)
    begin
        tgt_reg <= tgt_next;
    end

    // Result payload shows state after the beat
    always_ff @(posedge clk)
    begin
        if (execute)
        begin
            out_reg.pos_x         <= pos_next[0];
            out_reg.pos_y         <= pos_next[1];
            out_reg.pos_z         <= pos_next[2];
            out_reg.relative_mode <= rel_next;
            out_reg.inch_units    <= inch_next;
            out_reg.plane         <= plane_next;
        end
    end

`ifndef SYNTHESIS
    a_eol_clears: assert property (@(posedge clk) disable iff (!rst_n)
        execute && (cmd.op == OP_EOL || cmd.op == OP_EOL_SKIP)
        |=> pend_reg == '0 && off_en_reg && !aborted_reg)
        else $error("end of line left per-line state set");

    a_exec_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        execute |=> out_valid_reg)
        else $error("command executed without a result");

    a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
        plane_reg != 2'd3)
        else $error("plane select out of range");

    a_aborted_holds_pos: assert property (@(posedge clk) disable iff (!rst_n)
        aborted_reg && execute |=> pos_reg[0] == $past(pos_reg[0]) &&
        pos_reg[1] == $past(pos_reg[1]) && pos_reg[2] == $past(pos_reg[2]))
        else $error("aborted line changed the position");
`endif

endmodule

@@ hdl/gcode_modal_position_tracker_core.sv @@
// G-code modal position tracker. Takes one pre-tokenized word per beat plus an
// end-of-line beat, and returns exactly one result beat per input beat holding
// the committed X/Y/Z position (signed Q16.16) and the distance, unit and plane
// modes after that beat. Axis words set pending targets that commit at end of
// line, with the work offset added in absolute mode unless G53 appeared in the
// line; all additions saturate. Sustained rate is one beat per cycle while the
// output is not stalled: the back end carries out one command per cycle with a
// single 33-bit saturating add per axis on its path. A result beat passes
// through the classify register, a command queue entry and the result register
// after its input beat is accepted. The work offsets are to be written through
// the cfg port only while the tracker is idle; the block does not enforce this.
module gcode_modal_position_tracker_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [gmpt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [31:0]                     cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  gmpt_pkg::in_beat_t              in_data,
    output logic                            out_valid,
    input  logic                            out_stall,
    output gmpt_pkg::out_beat_t             out_data
);
    import gmpt_pkg::*;

    logic  fe_valid;
    cmd_t  fe_cmd;
    logic  q_full;
    logic  q_pop;
    logic  q_valid;
    cmd_t  q_cmd;

    // Front end: accept and classify
    gmpt_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (fe_valid),
        .cmd_full  (q_full),
        .cmd       (fe_cmd)
    );

    // Command queue between front and back
    gmpt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (fe_valid),
        .push_cmd   (fe_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_cmd)
    );

    // Back end: state update and result register
    gmpt_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd_valid (q_valid),
        .cmd       (q_cmd),
        .cmd_pop   (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule
